### rtl/core/gncc_pkg.sv
// Shared types and field widths for the chain cover core.
`default_nettype none

package gncc_pkg;

  localparam int HEIGHT_W       = 16;
  localparam int CHAIN_INDEX_W  = 6;
  localparam int CHAIN_COUNT_W  = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } gncc_state_t;

endpackage

`default_nettype wire

### rtl/core/gncc_if.sv
// Valid/ready channel interfaces for height items and chain results.
`default_nettype none

interface gncc_in_if import gncc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic                new_sequence;

  modport source (output valid, output height, output new_sequence, input ready);
  modport sink   (input valid, input height, input new_sequence, output ready);
endinterface

interface gncc_out_if import gncc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CHAIN_INDEX_W-1:0] chain_index;
  logic                     opened_chain;
  logic [CHAIN_COUNT_W-1:0] chain_count;
  logic                     overflow;

  modport source (output valid, output chain_index, output opened_chain,
                  output chain_count, output overflow, input ready);
  modport sink   (input valid, input chain_index, input opened_chain,
                  input chain_count, input overflow, output ready);
endinterface

`default_nettype wire

### rtl/core/gncc_ram.sv
// Chain last-height table: one write port, one registered read port.
`default_nettype none

module gncc_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/gncc_fit.sv
// Best-fit compare: entry fits and beats the current best candidate.
`default_nettype none

module gncc_fit #(
  parameter int DW = 16
) (
  input  wire logic [DW-1:0] entry_v,
  input  wire logic [DW-1:0] height,
  input  wire logic          found,
  input  wire logic [DW-1:0] best_v,
  output      logic          take
);

  assign take = (entry_v >= height) && (!found || (entry_v < best_v));

endmodule

`default_nettype wire

### rtl/core/greedy_nonincreasing_chain_cover_core.sv
// Top level: greedy non-increasing chain cover, one table scan per item.
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | height[15:0], new_sequence
//  out_ch  | out | valid/ready       | chain_index[5:0], opened_chain, chain_count[6:0], overflow
//
// After acceptance an item is scanned: one table read per open chain through the single read
// port, each registered read compared against the best fit so far, then a decide step that
// writes back and loads the output register. Ready returns in the cycle after the write-back,
// so a new item is accepted only once the last one is through its write-back.
// Reset clears the chain count and the sequencer; the table itself is not cleared.
// A result waits in the output register; the next item is accepted meanwhile and its
// write-back holds until that register frees up.
`default_nettype none

module greedy_nonincreasing_chain_cover_core import gncc_pkg::*; #(
  parameter int MAX_CHAINS  = 64,
  parameter int HEIGHT_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  gncc_in_if.sink    in_ch,
  gncc_out_if.source out_ch
);

  localparam int IW = $clog2(MAX_CHAINS);
  localparam int CW = $clog2(MAX_CHAINS + 1);
  localparam int SW = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;

  gncc_state_t state_r, state_nxt;

  logic [SW-1:0] h_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_idx_r;
  logic [SW-1:0] best_v_r;
  logic          out_vld_r;

  logic          in_acc;
  logic          rd_en;
  logic          scan_end;
  logic          load;
  logic          has_room;
  logic          take;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [SW-1:0] rdata;

  logic [IW-1:0] res_idx;
  logic [CW-1:0] res_cnt;
  logic [31:0]   res_idx_ext;
  logic [31:0]   res_cnt_ext;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign rd_en    = (state_r == ST_SCAN) && (rd_ptr_r < cnt_r);
  assign scan_end = !(rd_ptr_r < cnt_r) && !cmp_vld_r;
  assign has_room = cnt_r < CW'(MAX_CHAINS);

  gncc_ram #(
    .DEPTH (MAX_CHAINS),
    .AW    (IW),
    .DW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (h_r),
    .re    (rd_en),
    .raddr (rd_ptr_r[IW-1:0]),
    .rdata (rdata)
  );

  gncc_fit #(
    .DW (SW)
  ) u_fit (
    .entry_v (rdata),
    .height  (h_r),
    .found   (found_r),
    .best_v  (best_v_r),
    .take    (take)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    load        = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SCAN: ;
      ST_DONE: load = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  assign ram_we    = load && (found_r || has_room);
  assign ram_waddr = found_r ? best_idx_r : cnt_r[IW-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && in_ch.new_sequence) begin
      cnt_nxt = '0;
    end else if (load && !found_r && has_room) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    found_nxt  = found_r;
    if (in_acc) begin
      rd_ptr_nxt = '0;
      found_nxt  = 1'b0;
    end else begin
      if (rd_en) begin
        rd_ptr_nxt = rd_ptr_r + CW'(1);
      end
      if (cmp_vld_r && take) begin
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      rd_ptr_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cmp_vld_r <= rd_en;
      found_r   <= found_nxt;
      out_vld_r <= load || (out_vld_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      h_r <= in_ch.height[SW-1:0];
    end
    if (rd_en) begin
      cmp_idx_r <= rd_ptr_r[IW-1:0];
    end
    if (cmp_vld_r && take) begin
      best_idx_r <= cmp_idx_r;
      best_v_r   <= rdata;
    end
  end

  // result of the decide step
  always_comb begin
    if (found_r) begin
      res_idx = best_idx_r;
      res_cnt = cnt_r;
    end else if (has_room) begin
      res_idx = cnt_r[IW-1:0];
      res_cnt = cnt_r + CW'(1);
    end else begin
      res_idx = '0;
      res_cnt = cnt_r;
    end
  end

  assign res_idx_ext = 32'(res_idx);
  assign res_cnt_ext = 32'(res_cnt);

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.chain_index  <= res_idx_ext[CHAIN_INDEX_W-1:0];
      out_ch.opened_chain <= !found_r && has_room;
      out_ch.chain_count  <= res_cnt_ext[CHAIN_COUNT_W-1:0];
      out_ch.overflow     <= !found_r && !has_room;
    end
  end

  assign out_ch.valid = out_vld_r;

endmodule

`default_nettype wire
